[rtl/modular_exponentiation_assert.svh]
// Assertion macros for the port-level checker of the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular exponentiation check failed");

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular exponentiation check failed");

`endif

[rtl/mexp_pkg.sv]
// Shared types and codes of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_RESP
   } mexp_state_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_EXPONENT = 1'b0,
      REG_MODULUS  = 1'b1
   } mexp_reg_type;

endpackage

[rtl/mexp_mulmod.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps

module mexp_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_x,
   input  logic [WIDTH-1:0] op_y,
   input  logic [WIDTH-1:0] op_m,
   output logic             done,
   output logic [WIDTH-1:0] result
);

   localparam int CW = $clog2(WIDTH);
   localparam int EW = WIDTH + 3;
   localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] m_ff, m_in;

   logic [EW-1:0]    t_sum;
   logic [EW-1:0]    t_less_m;
   logic [EW-1:0]    t_less_2m;
   logic [WIDTH-1:0] acc_step;

   // With acc and x below m, 2*acc + x stays below 3m, so at most two
   // subtractions of m are needed; both are tried in parallel.
   always_comb begin
      t_sum     = {2'b00, acc_ff, 1'b0}
                + {3'b000, (x_ff & {WIDTH{y_ff[WIDTH-1]}})};
      t_less_m  = t_sum - {3'b000, m_ff};
      t_less_2m = t_sum - {2'b00, m_ff, 1'b0};
      if (!t_less_2m[EW-1]) begin
         acc_step = t_less_2m[WIDTH-1:0];
      end else if (!t_less_m[EW-1]) begin
         acc_step = t_less_m[WIDTH-1:0];
      end else begin
         acc_step = t_sum[WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_BIT;
         acc_in  = '0;
         x_in    = op_x;
         y_in    = op_y;
         m_in    = op_m;
      end else if (busy_ff) begin
         acc_in = acc_step;
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

[rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: sequencer and configuration registers.
//
// Each item raises req_base to the configured exponent modulo the configured
// modulus by left-to-right square-and-multiply. All arithmetic runs through one
// bit-serial modular multiplier; the base is first reduced by one pass through
// it, then every exponent bit costs a square and, for a one bit, a multiply.
// A modulus of 0 or 1 answers 0 without using the multiplier, and a base
// divisible by the modulus answers 0 after the reduction. busy stays high from
// acceptance through the cycle in which rsp_valid shows the result; the result
// is offered for that one cycle only and cannot be held off, so the receiver
// must take it then. The user must write configuration only while busy is
// low; the block itself does not enforce it.
`timescale 1ns / 1ps

module modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [WIDTH-1:0]                   req_base,
   output logic                               rsp_valid,
   output logic [WIDTH-1:0]                   rsp_power_mod,
   input  logic                               csr_we,
   input  logic [mexp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [WIDTH-1:0]                   csr_data
);

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);
   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

   mexp_pkg::mexp_state_type state_ff, state_in;

   logic [WIDTH-1:0] exp_reg_ff;
   logic [WIDTH-1:0] mod_reg_ff;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] e_sh_ff, e_sh_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic             mul_start;
   logic [WIDTH-1:0] mul_x;
   logic [WIDTH-1:0] mul_y;
   logic             mul_done;
   logic [WIDTH-1:0] mul_result;
   logic             advance;

   mexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_x  (mul_x),
      .op_y  (mul_y),
      .op_m  (mod_reg_ff),
      .done  (mul_done),
      .result(mul_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_reg_ff <= ONE;
         mod_reg_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            mexp_pkg::REG_EXPONENT: exp_reg_ff <= csr_data;
            mexp_pkg::REG_MODULUS:  mod_reg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      b_ff    <= b_in;
      r_ff    <= r_in;
      e_sh_ff <= e_sh_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      b_in      = b_ff;
      r_in      = r_ff;
      e_sh_in   = e_sh_ff;
      cnt_in    = cnt_ff;
      mul_start = 1'b0;
      mul_x     = r_ff;
      mul_y     = r_ff;
      advance   = 1'b0;

      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (start) begin
               e_sh_in = exp_reg_ff;
               cnt_in  = LAST_BIT;
               if (mod_reg_ff[WIDTH-1:1] == '0) begin
                  // A modulus of zero or one gives zero for every base.
                  r_in     = '0;
                  state_in = mexp_pkg::ST_RESP;
               end else begin
                  // Reduce the base: 1 * base mod m.
                  mul_start = 1'b1;
                  mul_x     = ONE;
                  mul_y     = req_base;
                  state_in  = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (mul_done) begin
               b_in = mul_result;
               if (mul_result == '0) begin
                  r_in     = '0;
                  state_in = mexp_pkg::ST_RESP;
               end else begin
                  r_in      = ONE;
                  mul_start = 1'b1;
                  mul_x     = ONE;
                  mul_y     = ONE;
                  state_in  = mexp_pkg::ST_SQUARE;
               end
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (mul_done) begin
               r_in = mul_result;
               if (e_sh_ff[WIDTH-1]) begin
                  mul_start = 1'b1;
                  mul_x     = mul_result;
                  mul_y     = b_ff;
                  state_in  = mexp_pkg::ST_MULT;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         mexp_pkg::ST_MULT: begin
            if (mul_done) begin
               r_in    = mul_result;
               advance = 1'b1;
            end
         end
         mexp_pkg::ST_RESP: begin
            state_in = mexp_pkg::ST_IDLE;
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase

      // Move to the next exponent bit, or finish after the last one.
      if (advance) begin
         if (cnt_ff == '0) begin
            state_in = mexp_pkg::ST_RESP;
         end else begin
            cnt_in    = cnt_ff - 1'b1;
            e_sh_in   = {e_sh_ff[WIDTH-2:0], 1'b0};
            mul_start = 1'b1;
            mul_x     = mul_result;
            mul_y     = mul_result;
            state_in  = mexp_pkg::ST_SQUARE;
         end
      end
   end

   assign busy          = (state_ff != mexp_pkg::ST_IDLE);
   assign rsp_valid     = (state_ff == mexp_pkg::ST_RESP);
   assign rsp_power_mod = r_ff;

endmodule

[rtl/mexp_checker.sv]
// Port-level checks of the modular exponentiation block and their binding.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module mexp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // A result is shown for a single cycle.
   `MEXP_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)

   // An accepted item keeps the block busy until its result.
   `MEXP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // Results only come from an item in flight.
   `MEXP_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)

   // The block is free again right after delivering a result.
   `MEXP_ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_valid, !busy)

   // Busy rises only by accepting an item.
   `MEXP_ASSERT_NEXT(a_busy_from_start, clock, reset, !busy && !start, !busy)

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid)
);

[dv/modular_exponentiation_checker.sv]
// Checker that predicts and compares every result of the modular exponentiation block.
`timescale 1ns / 1ps

module modular_exponentiation_checker #(
   parameter int WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [WIDTH-1:0]                 req_base,
   input  logic                             rsp_valid,
   input  logic [WIDTH-1:0]                 rsp_power_mod,
   input  logic                             csr_we,
   input  logic [mexp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [WIDTH-1:0]                 csr_data,
   output int                               mismatch_count,
   output int                               pending_count
);

   typedef struct {
      logic [WIDTH-1:0] base;
      logic [WIDTH-1:0] power_mod;
   } power_entry_type;

   power_entry_type  pending_powers[$];
   logic [WIDTH-1:0] exponent_copy;
   logic [WIDTH-1:0] modulus_copy;

   initial begin
      mismatch_count = 0;
      pending_count = 0;
   end

   // Left-to-right square-and-multiply; operands stay below the modulus, so a
   // double-width product never overflows before it is reduced.
   function automatic logic [WIDTH-1:0] power_mod_of(input logic [WIDTH-1:0] base,
                                                     input logic [WIDTH-1:0] exponent,
                                                     input logic [WIDTH-1:0] modulus);
      logic [2*WIDTH-1:0] acc;
      logic [2*WIDTH-1:0] reduced_base;
      logic [2*WIDTH-1:0] wide_modulus;
      if (modulus == '0)
         return '0;
      wide_modulus = {{WIDTH{1'b0}}, modulus};
      reduced_base = {{WIDTH{1'b0}}, base} % wide_modulus;
      if (reduced_base == '0)
         return '0;
      acc = (2*WIDTH)'(1);
      for (int i = WIDTH - 1; i >= 0; i--) begin
         acc = (acc * acc) % wide_modulus;
         if (exponent[i])
            acc = (acc * reduced_base) % wide_modulus;
      end
      return acc[WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      power_entry_type head;
      if (reset) begin
         exponent_copy = WIDTH'(1);
         modulus_copy = '1;
         pending_powers.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_powers.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual power_mod %h",
                        $time, rsp_power_mod);
               mismatch_count <= mismatch_count + 1;
            end else begin
               head = pending_powers.pop_front();
               if (rsp_power_mod !== head.power_mod) begin
                  $display("%0t: power_mod mismatch for base %h: expected %h, actual %h",
                           $time, head.base, head.power_mod, rsp_power_mod);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (start && !busy)
            pending_powers.push_back('{req_base,
                                       power_mod_of(req_base, exponent_copy, modulus_copy)});
         if (csr_we) begin
            if (csr_index == mexp_pkg::REG_EXPONENT)
               exponent_copy = csr_data;
            else if (csr_index == mexp_pkg::REG_MODULUS)
               modulus_copy = csr_data;
         end
         pending_count <= pending_powers.size();
      end
   end

endmodule

[dv/tb_top.sv]
// Testbench top of the modular exponentiation block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int WIDTH = 32;
   // Covers the longest items plus sender gaps, several times over.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [WIDTH-1:0]                 req_base = '0;
   logic                             rsp_valid;
   logic [WIDTH-1:0]                 rsp_power_mod;
   logic                             csr_we = 1'b0;
   logic [mexp_pkg::CSR_INDEX_W-1:0] csr_index = mexp_pkg::REG_EXPONENT;
   logic [WIDTH-1:0]                 csr_data = '0;

   int                     mismatch_count;
   int                     pending_count;
   int unsigned            cycle_count = 0;
   int                     idle_pct = 0;
   logic [WIDTH-1:0]       current_modulus = '1;

   always #4 clock = ~clock;

   modular_exponentiation #(.WIDTH(WIDTH)) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_base     (req_base),
      .rsp_valid    (rsp_valid),
      .rsp_power_mod(rsp_power_mod),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   modular_exponentiation_checker #(.WIDTH(WIDTH)) power_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_power_mod (rsp_power_mod),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Busy only changes at a rising edge, so an item raised at a falling edge
   // with busy low is taken at the next rising edge.
   task automatic send_base(input logic [WIDTH-1:0] base);
      while ($urandom_range(99) < idle_pct)
         @(negedge clock);
      while (busy)
         @(negedge clock);
      start = 1'b1;
      req_base = base;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_reg(input mexp_pkg::mexp_reg_type index,
                            input logic [WIDTH-1:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic settle();
      while (pending_count != 0 || busy)
         @(negedge clock);
   endtask

   task automatic configure(input logic [WIDTH-1:0] exponent, input logic [WIDTH-1:0] modulus);
      settle();
      write_reg(mexp_pkg::REG_EXPONENT, exponent);
      write_reg(mexp_pkg::REG_MODULUS, modulus);
      current_modulus = modulus;
   endtask

   // Mixes multiples of the modulus, values near it, edge values and noise.
   function automatic logic [WIDTH-1:0] pick_base(input logic [WIDTH-1:0] modulus);
      int unsigned multiple;
      case ($urandom_range(9))
         0, 1: begin
            if (modulus == 0)
               return $urandom;
            multiple = $urandom_range(32'hFFFF_FFFF / modulus, 0);
            return multiple * modulus;
         end
         2: return $urandom_range(3);
         3: return modulus + $urandom_range(2) - 1;
         4: return $urandom_range(1) ? '1 : '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_items(input int count);
      repeat (count)
         send_base(pick_base(current_modulus));
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Values left by reset: exponent one, modulus all ones.
      send_base(32'h0000_0000);
      send_base(32'h0000_0001);
      send_base(32'hFFFF_FFFF);
      send_base(32'hFFFF_FFFE);
      send_base(32'h8000_0000);

      configure(32'd17, 32'd3233);
      send_base(32'd65);
      send_base(32'd6466);
      send_base(32'd3232);

      // Exponent zero gives one unless the base is a multiple of the modulus.
      configure(32'd0, 32'd97);
      send_base(32'd0);
      send_base(32'd485);
      send_base(32'd96);
      send_base(32'hFFFF_FFFF);

      configure('1, '1);
      send_base(32'd2);
      send_base(32'hFFFF_FFFE);
      send_base(32'h1234_5678);

      // A modulus of one reduces everything to zero.
      configure(32'd5, 32'd1);
      send_base(32'd7);
      send_base(32'd0);

      // A modulus of zero is answered with zero.
      configure(32'd3, 32'd0);
      send_base(32'd7);
      send_base(32'hFFFF_FFFF);

      configure(32'd2, 32'd2);
      send_base(32'hFFFF_FFFF);
      send_base(32'hFFFF_FFFE);

      idle_pct = 0;
      configure($urandom, $urandom | 32'h8000_0001);
      random_items(34);

      idle_pct = 84;
      configure('1, '1);
      random_items(34);

      idle_pct = 7;
      configure(32'd0, $urandom_range(1000, 2));
      random_items(34);

      idle_pct = 0;
      configure(32'd65537, $urandom);
      random_items(34);

      idle_pct = 84;
      configure($urandom, 32'd2);
      random_items(34);

      idle_pct = 7;
      configure(32'd1, $urandom_range(255, 3));
      random_items(34);

      idle_pct = 84;
      configure($urandom, 32'd1);
      random_items(34);

      idle_pct = 0;
      configure($urandom, $urandom);
      random_items(34);

      settle();
      repeat (50) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
